/* hw/rtl/etc_pkg.sv */
// ----------------------------------------------------------------------------
// etc_pkg
// Shared constants, codes and types of the effect timeline controller.
// ----------------------------------------------------------------------------
package etc_pkg;

  localparam int TimeW   = 32;
  localparam int FrameW  = 12;
  localparam int CountW  = 13;
  localparam int SpeedW  = 16;
  localparam int DeltaW  = 16;
  localparam int StepW   = 24;
  localparam int RatioW  = 16;
  localparam int CmdW    = 3;
  localparam int ModeW   = 2;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int DivQW   = 48;
  localparam int DivCntW = 6;

  localparam logic [RatioW-1:0] RatioOne  = 16'd32768;
  localparam logic [CountW-1:0] MaxFrames = 13'd4096;

  localparam logic [CmdW-1:0] CMD_TICK  = 3'd0;
  localparam logic [CmdW-1:0] CMD_PLAY  = 3'd1;
  localparam logic [CmdW-1:0] CMD_PAUSE = 3'd2;
  localparam logic [CmdW-1:0] CMD_RESET = 3'd3;
  localparam logic [CmdW-1:0] CMD_STOP  = 3'd4;

  localparam logic [ModeW-1:0] MODE_PLAY  = 2'd0;
  localparam logic [ModeW-1:0] MODE_PAUSE = 2'd1;
  localparam logic [ModeW-1:0] MODE_STOP  = 2'd2;

  localparam logic [2:0] REG_PLAYBACK_SPEED = 3'd0;
  localparam logic [2:0] REG_START_DELAY    = 3'd1;
  localparam logic [2:0] REG_DURATION       = 3'd2;
  localparam logic [2:0] REG_LIFE_TIME      = 3'd3;
  localparam logic [2:0] REG_LOOPING        = 3'd4;
  localparam logic [2:0] REG_ANIM_ENABLE    = 3'd5;
  localparam logic [2:0] REG_ANIM_SPEED     = 3'd6;
  localparam logic [2:0] REG_SPRITE_FRAMES  = 3'd7;

  localparam logic [1:0] DIV_MOD   = 2'd0;
  localparam logic [1:0] DIV_RATIO = 2'd1;
  localparam logic [1:0] DIV_FRAME = 2'd2;

  typedef struct packed {
    logic [SpeedW-1:0] playback_speed;
    logic [TimeW-1:0]  start_delay;
    logic [TimeW-1:0]  duration;
    logic [TimeW-1:0]  life_time;
    logic              looping;
    logic              anim_enable;
    logic [SpeedW-1:0] anim_speed;
    logic [CountW-1:0] sprite_frames;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       exec;
    logic       elap;
    logic       chk;
    logic       act;
    logic       mod_take;
    logic       cur_act;
    logic       rat_full;
    logic       rdiv_take;
    logic       frm_mul;
    logic       frm_sum;
    logic       frm_clamp;
    logic       fdiv_take;
    logic       out_load;
    logic       div_start;
    logic [1:0] div_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic before_delay;
    logic ge_d;
    logic loop_on;
    logic anim_on;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* hw/rtl/etc_if.sv */
// ----------------------------------------------------------------------------
// etc_if
// Request and result channels of the effect timeline controller.
// ----------------------------------------------------------------------------
interface etc_req_if import etc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [DeltaW-1:0] delta_time;

  modport source(output valid, command, delta_time, input ready);
  modport sink(input valid, command, delta_time, output ready);
endinterface

interface etc_res_if import etc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              started;
  logic              finished;
  logic [RatioW-1:0] progress_ratio;
  logic [FrameW-1:0] sprite_frame;
  logic [StepW-1:0]  step_time;

  modport source(output valid, started, finished, progress_ratio, sprite_frame, step_time,
                 input ready);
  modport sink(input valid, started, finished, progress_ratio, sprite_frame, step_time,
               output ready);
endinterface

/* hw/rtl/etc_regs.sv */
// ----------------------------------------------------------------------------
// etc_regs
// APB configuration registers, one register per word.
// ----------------------------------------------------------------------------
module etc_regs import etc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.playback_speed <= 16'd256;
      cfg.start_delay    <= '0;
      cfg.duration       <= 32'd1;
      cfg.life_time      <= '0;
      cfg.looping        <= 1'b0;
      cfg.anim_enable    <= 1'b0;
      cfg.anim_speed     <= '0;
      cfg.sprite_frames  <= 13'd1;
    end else if (wr_en) begin
      unique case (index)
        REG_PLAYBACK_SPEED: cfg.playback_speed <= pwdata[SpeedW-1:0];
        REG_START_DELAY:    cfg.start_delay    <= pwdata[TimeW-1:0];
        REG_DURATION:       cfg.duration       <= pwdata[TimeW-1:0];
        REG_LIFE_TIME:      cfg.life_time      <= pwdata[TimeW-1:0];
        REG_LOOPING:        cfg.looping        <= pwdata[0];
        REG_ANIM_ENABLE:    cfg.anim_enable    <= pwdata[0];
        REG_ANIM_SPEED:     cfg.anim_speed     <= pwdata[SpeedW-1:0];
        REG_SPRITE_FRAMES:  cfg.sprite_frames  <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_PLAYBACK_SPEED: prdata = {16'd0, cfg.playback_speed};
      REG_START_DELAY:    prdata = cfg.start_delay;
      REG_DURATION:       prdata = cfg.duration;
      REG_LIFE_TIME:      prdata = cfg.life_time;
      REG_LOOPING:        prdata = {31'd0, cfg.looping};
      REG_ANIM_ENABLE:    prdata = {31'd0, cfg.anim_enable};
      REG_ANIM_SPEED:     prdata = {16'd0, cfg.anim_speed};
      REG_SPRITE_FRAMES:  prdata = {19'd0, cfg.sprite_frames};
      default:            prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/etc_div.sv */
// ----------------------------------------------------------------------------
// etc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etc_div import etc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DivQW-1:0]   dividend,
  input  logic [TimeW-1:0]   rem_init,
  input  logic [TimeW-1:0]   divisor,
  input  logic [DivCntW-1:0] steps,
  output logic               done,
  output logic [DivQW-1:0]   quotient,
  output logic [TimeW-1:0]   remainder
);

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [TimeW-1:0]   div_r;
  logic [TimeW:0]     trial;
  logic               fits;

  assign trial = {remainder, quotient[DivQW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DivCntW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DivCntW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= rem_init;
      div_r     <= divisor;
      cnt       <= steps;
    end else if (busy) begin
      quotient  <= {quotient[DivQW-2:0], fits};
      remainder <= fits ? TimeW'(trial - {1'b0, div_r}) : trial[TimeW-1:0];
      cnt       <= cnt - DivCntW'(1);
    end
  end

endmodule

/* hw/rtl/etc_ctrl.sv */
// ----------------------------------------------------------------------------
// etc_ctrl
// Sequencer of the timeline update, one request at a time.
// ----------------------------------------------------------------------------
module etc_ctrl import etc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_ELAP = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_ACT  = 4'd4;
  localparam logic [3:0] S_MOD  = 4'd5;
  localparam logic [3:0] S_CACT = 4'd6;
  localparam logic [3:0] S_RAT  = 4'd7;
  localparam logic [3:0] S_RDIV = 4'd8;
  localparam logic [3:0] S_FRM  = 4'd9;
  localparam logic [3:0] S_FSUM = 4'd10;
  localparam logic [3:0] S_FSEL = 4'd11;
  localparam logic [3:0] S_FDIV = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.is_tick ? S_ELAP : S_CACT;
      end
      S_ELAP: begin
        cmd.elap   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        state_next = sts.before_delay ? S_OUT : S_ACT;
      end
      S_ACT: begin
        cmd.act = 1'b1;
        if (sts.ge_d && sts.loop_on) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MOD;
          state_next    = S_MOD;
        end else begin
          state_next = S_RAT;
        end
      end
      S_MOD: begin
        if (sts.div_done) begin
          cmd.mod_take = 1'b1;
          state_next   = S_RAT;
        end
      end
      S_CACT: begin
        cmd.cur_act = 1'b1;
        state_next  = S_RAT;
      end
      S_RAT: begin
        if (sts.ge_d) begin
          cmd.rat_full = 1'b1;
          state_next   = sts.is_tick ? S_FRM : S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATIO;
          state_next    = S_RDIV;
        end
      end
      S_RDIV: begin
        if (sts.div_done) begin
          cmd.rdiv_take = 1'b1;
          state_next    = sts.is_tick ? S_FRM : S_OUT;
        end
      end
      S_FRM: begin
        if (sts.anim_on) begin
          cmd.frm_mul = 1'b1;
          state_next  = S_FSUM;
        end else begin
          state_next = S_OUT;
        end
      end
      S_FSUM: begin
        cmd.frm_sum = 1'b1;
        state_next  = S_FSEL;
      end
      S_FSEL: begin
        if (sts.loop_on) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_FRAME;
          state_next    = S_FDIV;
        end else begin
          cmd.frm_clamp = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_FDIV: begin
        if (sts.div_done) begin
          cmd.fdiv_take = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the output register is still full");

  a_div_start_state: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (state == S_ACT || state == S_RAT || state == S_FSEL))
    else $error("divider started from an unexpected state");

  a_mod_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && !sts.div_done) |=> (state == S_MOD))
    else $error("modulo wait left before the divider finished");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state == S_EXEC))
    else $error("accepted request did not start execution");
`endif

endmodule

/* hw/rtl/etc_dp.sv */
// ----------------------------------------------------------------------------
// etc_dp
// Timeline datapath: elapsed time, flags, progress, sprite frame, result.
// ----------------------------------------------------------------------------
module etc_dp import etc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic [CmdW-1:0]   command,
  input  logic [DeltaW-1:0] delta_time,
  input  ctrl_cmd_t         cmd,
  output ctrl_sts_t         sts,
  etc_res_if.source         result
);

  logic [CmdW-1:0]   cmd_r;
  logic [DeltaW-1:0] dt_r;
  logic [TimeW-1:0]  elapsed;
  logic [ModeW-1:0]  run_mode;
  logic              started_flag;
  logic              finished_flag;
  logic [FrameW-1:0] frame_index;
  logic [StepW-1:0]  step_r;
  logic [TimeW-1:0]  active;
  logic [RatioW-1:0] progress;
  logic [31:0]       prod_lo;
  logic [31:0]       prod_hi;
  logic [TimeW:0]    fr;

  logic [31:0]        speed_prod;
  logic [TimeW:0]     elap_sum;
  logic [TimeW-1:0]   d_eff;
  logic [TimeW:0]     fin_limit;
  logic               fin_hit;
  logic [CountW-1:0]  total;
  logic [CountW-1:0]  total_m1;
  logic [TimeW-1:0]   since_start;

  logic               div_start;
  logic [DivQW-1:0]   div_dividend;
  logic [TimeW-1:0]   div_rem_init;
  logic [TimeW-1:0]   div_divisor;
  logic [DivCntW-1:0] div_steps;
  logic               div_done;
  logic [DivQW-1:0]   div_quo;
  logic [TimeW-1:0]   div_rem;

  assign speed_prod  = {16'd0, cfg.playback_speed} * {16'd0, dt_r};
  assign elap_sum    = {1'b0, elapsed} + {{(TimeW + 1 - StepW){1'b0}}, step_r};
  assign d_eff       = (cfg.duration == '0) ? TimeW'(1) : cfg.duration;
  assign fin_limit   = {1'b0, d_eff} + {1'b0, cfg.life_time};
  assign fin_hit     = {1'b0, active} >= fin_limit;
  assign total       = (cfg.sprite_frames > MaxFrames) ? MaxFrames : cfg.sprite_frames;
  assign total_m1    = total - CountW'(1);
  assign since_start = elapsed - cfg.start_delay;

  assign sts.is_tick      = (cmd_r == CMD_TICK);
  assign sts.before_delay = elapsed < cfg.start_delay;
  assign sts.ge_d         = active >= d_eff;
  assign sts.loop_on      = cfg.looping;
  assign sts.anim_on      = cfg.anim_enable && (cfg.sprite_frames != '0);
  assign sts.div_done     = div_done;
  assign sts.out_free     = !result.valid || result.ready;

  always_comb begin
    div_start    = cmd.div_start;
    div_dividend = '0;
    div_rem_init = '0;
    div_divisor  = d_eff;
    div_steps    = DivCntW'(TimeW);
    unique case (cmd.div_sel)
      DIV_MOD: begin
        div_dividend = {active, {(DivQW - TimeW){1'b0}}};
      end
      DIV_RATIO: begin
        div_rem_init = active;
        div_steps    = DivCntW'(RatioW - 1);
      end
      DIV_FRAME: begin
        div_dividend = {fr, {(DivQW - TimeW - 1){1'b0}}};
        div_divisor  = {{(TimeW - CountW){1'b0}}, total};
        div_steps    = DivCntW'(TimeW + 1);
      end
      default: ;
    endcase
  end

  etc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .rem_init  (div_rem_init),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // timeline state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= '0;
      run_mode      <= MODE_PLAY;
      started_flag  <= 1'b0;
      finished_flag <= 1'b0;
      frame_index   <= '0;
    end else begin
      if (cmd.exec && (cmd_r != CMD_TICK)) begin
        unique case (cmd_r)
          CMD_PLAY:  run_mode <= MODE_PLAY;
          CMD_PAUSE: run_mode <= MODE_PAUSE;
          CMD_RESET: begin
            elapsed       <= '0;
            started_flag  <= 1'b0;
            finished_flag <= 1'b0;
            run_mode      <= MODE_PLAY;
          end
          CMD_STOP: begin
            elapsed       <= '0;
            started_flag  <= 1'b0;
            finished_flag <= 1'b0;
            run_mode      <= MODE_STOP;
          end
          default: ;
        endcase
      end
      if (cmd.elap) begin
        elapsed <= elap_sum[TimeW] ? '1 : elap_sum[TimeW-1:0];
      end
      if (cmd.chk) begin
        started_flag <= !sts.before_delay;
      end
      if (cmd.act && sts.ge_d && !cfg.looping && fin_hit) begin
        finished_flag <= 1'b1;
      end
      if (cmd.mod_take) begin
        elapsed <= cfg.start_delay + div_rem;
      end
      if (cmd.frm_clamp) begin
        frame_index <= (fr > {{(TimeW + 1 - CountW){1'b0}}, total_m1}) ?
                       total_m1[FrameW-1:0] : fr[FrameW-1:0];
      end
      if (cmd.fdiv_take) begin
        frame_index <= div_rem[FrameW-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= command;
      dt_r  <= delta_time;
    end
    if (cmd.exec) begin
      step_r <= ((cmd_r == CMD_TICK) && (run_mode == MODE_PLAY)) ? speed_prod[31:8] : '0;
    end
    if (cmd.chk) begin
      if (sts.before_delay) begin
        progress <= '0;
      end else begin
        active <= since_start;
      end
    end
    if (cmd.mod_take) begin
      active <= div_rem;
    end
    if (cmd.cur_act) begin
      active <= sts.before_delay ? '0 : since_start;
    end
    if (cmd.rat_full) begin
      progress <= RatioOne;
    end
    if (cmd.rdiv_take) begin
      progress <= {1'b0, div_quo[RatioW-2:0]};
    end
    if (cmd.frm_mul) begin
      prod_lo <= {16'd0, active[15:0]} * {16'd0, cfg.anim_speed};
      prod_hi <= {16'd0, active[TimeW-1:16]} * {16'd0, cfg.anim_speed};
    end
    if (cmd.frm_sum) begin
      fr <= {1'b0, prod_hi} + {17'd0, prod_lo[31:16]};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.started        <= started_flag;
      result.finished       <= finished_flag;
      result.progress_ratio <= progress;
      result.sprite_frame   <= frame_index;
      result.step_time      <= step_r;
    end
  end

endmodule

/* hw/rtl/effect_timeline_controller.sv */
// ----------------------------------------------------------------------------
// effect_timeline_controller
// Timeline of one visual effect: elapsed time, run mode, flags, sprite frame.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the next is taken as soon as the
// result sits in the output register. A non-tick request sets the active
// time, plus the progress divide when the active time is below the
// duration. A tick before the start delay updates the elapsed time, the
// started flag and the progress. Any other tick adds the modulo by the
// duration when looping wraps, the progress divide, and for the sprite
// frame when animation is on a multiply and a sum, then a modulo by the
// frame count when looping, else a clamp. The single shared divider yields
// one quotient bit per cycle; a result not taken holds the block in S_OUT.
module effect_timeline_controller import etc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  etc_req_if.sink          request,
  etc_res_if.source        result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  assign request.ready = in_ready;

  etc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  etc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .command    (request.command),
    .delta_time (request.delta_time),
    .cmd        (cmd),
    .sts        (sts),
    .result     (result)
  );

endmodule
